// ----- rtl/core/mau_pkg.sv -----
package mau_pkg;

   // Residue and modulus width
   localparam int VALUE_WIDTH = 31;
   // Signed Euclid coefficient width (holds +/- modulus and twice its products)
   localparam int COEF_WIDTH = VALUE_WIDTH + 3;
   // Bit counter width for one serial pass over a residue
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int EXP_WIDTH = 63;
   localparam int FUNC_WIDTH = 3;
   localparam logic [VALUE_WIDTH-1:0] DEFAULT_MODULUS = VALUE_WIDTH'(998244353);

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_POW = 3'd4,
      FUNC_INV = 3'd5
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_EXEC,
      ST_EUC,
      ST_EUC_WAIT,
      ST_FIX,
      ST_FIN,
      ST_MUL,
      ST_POW,
      ST_POW_R,
      ST_POW_X,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/mau_divider.sv -----
module mau_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [mau_pkg::VALUE_WIDTH-1:0]      dividend,
   input  logic [mau_pkg::VALUE_WIDTH-1:0]      divisor,
   input  logic signed [mau_pkg::COEF_WIDTH-1:0] coef,
   output logic                                 done,
   output logic [mau_pkg::VALUE_WIDTH-1:0]      quotient,
   output logic [mau_pkg::VALUE_WIDTH-1:0]      remainder,
   output logic signed [mau_pkg::COEF_WIDTH-1:0] product
);
   import mau_pkg::*;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0]        rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]        quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0]        dvs_ff, dvs_in;
   logic signed [COEF_WIDTH-1:0]  coef_ff, coef_in;
   logic signed [COEF_WIDTH-1:0]  acc_ff, acc_in;
   logic [VALUE_WIDTH:0]          trial;
   logic [VALUE_WIDTH:0]          diff;
   logic                          qbit;

   // One restoring step a cycle; quotient bits also scale the coefficient
   always_comb begin
      trial   = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      qbit    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      coef_in = coef_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(VALUE_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         coef_in = coef;
         acc_in  = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], qbit};
         acc_in = (acc_ff <<< 1) + (qbit ? coef_ff : '0);
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      coef_ff <= coef_in;
      acc_ff  <= acc_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign product   = acc_ff;

endmodule

// ----- rtl/core/mau_mulmod.sv -----
module mau_mulmod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mau_pkg::VALUE_WIDTH-1:0] mul_x,
   input  logic [mau_pkg::VALUE_WIDTH-1:0] mul_y,
   input  logic [mau_pkg::VALUE_WIDTH-1:0] modulus,
   output logic                            done,
   output logic [mau_pkg::VALUE_WIDTH-1:0] prod
);
   import mau_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] y_ff, y_in;
   logic [VALUE_WIDTH-1:0] m_ff, m_in;
   logic [VALUE_WIDTH:0]   dbl;
   logic [VALUE_WIDTH:0]   dbl_red;
   logic [VALUE_WIDTH:0]   sum;
   logic [VALUE_WIDTH:0]   sum_red;

   // Double-and-add, multiplier bits taken high first, reduced each step
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum     = dbl_red + (y_ff[VALUE_WIDTH-1] ? {1'b0, x_ff} : '0);
      sum_red = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(VALUE_WIDTH);
         acc_in  = '0;
         x_in    = mul_x;
         y_in    = mul_y;
         m_in    = modulus;
      end else if (busy_ff) begin
         acc_in = sum_red[VALUE_WIDTH-1:0];
         y_in   = {y_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- rtl/core/modular_arithmetic_unit_core.sv -----
// Per word: add/sub run two operand reductions in the divider, mul then one multiplication,
// pow a squaring per exponent bit plus a multiplication first when the bit is set, inv one
// division per Euclid step, div the same plus a final multiplication; a negative coefficient
// adds a fix division. Words are taken one at a time; the bit-serial divider and the bit-serial
// modular multiplier each retire one bit per cycle.
// A new word is taken while the previous result waits in the output register.
// Reset is synchronous: modulus returns to 998244353, control and the output valid clear.
module modular_arithmetic_unit_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // operand_a[30:0], operand_b[61:31], exponent[124:62]
   input  logic [2:0]   req_tuser,  // func[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // result[30:0]
   input  logic         csr_wen,
   input  logic [30:0]  csr_wdata
);
   import mau_pkg::*;

   state_type                    state_ff, state_in;
   logic [VALUE_WIDTH-1:0]       mod_ff;
   logic [FUNC_WIDTH-1:0]        func_ff, func_in;
   logic [VALUE_WIDTH-1:0]       opa_ff, opa_in;
   logic [VALUE_WIDTH-1:0]       opb_ff, opb_in;
   logic [EXP_WIDTH-1:0]         exp_ff, exp_in;
   logic [VALUE_WIDTH-1:0]       s_ff, s_in;
   logic [VALUE_WIDTH-1:0]       t_ff, t_in;
   logic signed [COEF_WIDTH-1:0] c0_ff, c0_in;
   logic signed [COEF_WIDTH-1:0] c1_ff, c1_in;
   logic [VALUE_WIDTH-1:0]       res_ff, res_in;
   logic [VALUE_WIDTH-1:0]       x_ff, x_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]       rsp_data_ff, rsp_data_in;

   logic                         div_start, div_done;
   logic [VALUE_WIDTH-1:0]       div_dividend, div_divisor;
   logic signed [COEF_WIDTH-1:0] div_coef, div_prod;
   logic [VALUE_WIDTH-1:0]       div_quo, div_rem;
   logic                         mul_start, mul_done;
   logic [VALUE_WIDTH-1:0]       mul_x, mul_y, mul_prod;

   logic                         req_fire;
   logic [VALUE_WIDTH:0]         sum_add, sum_sub;
   logic signed [COEF_WIDTH-1:0] mod_ext, fin1, fin2;

   assign req_fire = req_tvalid && req_tready;
   assign mod_ext  = signed'(COEF_WIDTH'(mod_ff));

   mau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .coef      (div_coef),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem),
      .product   (div_prod)
   );

   mau_mulmod u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_x   (mul_x),
      .mul_y   (mul_y),
      .modulus (mod_ff),
      .done    (mul_done),
      .prod    (mul_prod)
   );

   // Hold modulus; the user must write it only between words, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= DEFAULT_MODULUS;
      end else if (csr_wen) begin
         mod_ff <= csr_wdata;
      end
   end

   // Sequencer: reduce operands, then run the selected operation (a zero modulus gives result zero at once)
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      exp_in       = exp_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      res_in       = res_ff;
      x_in         = x_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = (state_ff == ST_IDLE);
      div_start    = 1'b0;
      div_dividend = opa_ff;
      div_divisor  = mod_ff;
      div_coef     = '0;
      mul_start    = 1'b0;
      mul_x        = opa_ff;
      mul_y        = opb_ff;
      sum_add      = {1'b0, opa_ff} + {1'b0, opb_ff};
      sum_sub      = {1'b0, opa_ff} + ({1'b0, mod_ff} - {1'b0, opb_ff});
      fin1         = (c0_ff < 0) ? c0_ff + mod_ext : c0_ff;
      fin2         = (fin1 >= mod_ext) ? fin1 - mod_ext : fin1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in = req_tuser;
               opa_in  = req_tdata[30:0];
               opb_in  = req_tdata[61:31];
               exp_in  = req_tdata[124:62];
               if (mod_ff == '0) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = req_tdata[30:0];
                  state_in     = ST_RED_A;
               end
            end
         end
         ST_RED_A: begin
            if (div_done) begin
               opa_in       = div_rem;
               div_start    = 1'b1;
               div_dividend = opb_ff;
               state_in     = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (div_done) begin
               opb_in   = div_rem;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            s_in  = mod_ff;
            c0_in = '0;
            c1_in = COEF_WIDTH'(1);
            unique case (func_ff)
               FUNC_ADD: begin
                  res_in   = (sum_add >= {1'b0, mod_ff}) ? VALUE_WIDTH'(sum_add - {1'b0, mod_ff})
                                                         : sum_add[VALUE_WIDTH-1:0];
                  state_in = ST_DONE;
               end
               FUNC_SUB: begin
                  res_in   = (sum_sub >= {1'b0, mod_ff}) ? VALUE_WIDTH'(sum_sub - {1'b0, mod_ff})
                                                         : sum_sub[VALUE_WIDTH-1:0];
                  state_in = ST_DONE;
               end
               FUNC_MUL: begin
                  mul_start = 1'b1;
                  state_in  = ST_MUL;
               end
               FUNC_DIV: begin
                  t_in     = opb_ff;
                  state_in = ST_EUC;
               end
               FUNC_POW: begin
                  res_in   = (mod_ff == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
                  x_in     = opa_ff;
                  state_in = ST_POW;
               end
               FUNC_INV: begin
                  t_in     = opa_ff;
                  state_in = ST_EUC;
               end
               default: begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_EUC: begin
            if (t_ff == '0) begin
               if (c0_ff < 0 && s_ff != '0) begin
                  div_start    = 1'b1;
                  div_dividend = mod_ff;
                  div_divisor  = s_ff;
                  state_in     = ST_FIX;
               end else begin
                  state_in = ST_FIN;
               end
            end else begin
               div_start    = 1'b1;
               div_dividend = s_ff;
               div_divisor  = t_ff;
               div_coef     = c1_ff;
               state_in     = ST_EUC_WAIT;
            end
         end
         ST_EUC_WAIT: begin
            if (div_done) begin
               s_in     = t_ff;
               t_in     = div_rem;
               c0_in    = c1_ff;
               c1_in    = c0_ff - div_prod;
               state_in = ST_EUC;
            end
         end
         ST_FIX: begin
            if (div_done) begin
               c0_in    = c0_ff + signed'(COEF_WIDTH'(div_quo));
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (func_ff == FUNC_DIV) begin
               mul_start = 1'b1;
               mul_y     = fin2[VALUE_WIDTH-1:0];
               state_in  = ST_MUL;
            end else begin
               res_in   = fin2[VALUE_WIDTH-1:0];
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               res_in   = mul_prod;
               state_in = ST_DONE;
            end
         end
         ST_POW: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               mul_x     = res_ff;
               mul_y     = x_ff;
               state_in  = ST_POW_R;
            end else begin
               mul_start = 1'b1;
               mul_x     = x_ff;
               mul_y     = x_ff;
               state_in  = ST_POW_X;
            end
         end
         ST_POW_R: begin
            if (mul_done) begin
               res_in    = mul_prod;
               mul_start = 1'b1;
               mul_x     = x_ff;
               mul_y     = x_ff;
               state_in  = ST_POW_X;
            end
         end
         ST_POW_X: begin
            if (mul_done) begin
               x_in     = mul_prod;
               exp_in   = exp_ff >> 1;
               state_in = ST_POW;
            end
         end
         ST_DONE: begin
            // Load the output word once the register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      exp_ff      <= exp_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      res_ff      <= res_in;
      x_ff        <= x_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

// ----- rtl/core/mau_checker.sv -----
module mau_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic         csr_wen,
   input logic [30:0]  csr_wdata
);

   // Stalled output word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output word changed under stall");

   // Pad bit of the result word stays clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("result pad bit set");

   // One word in flight: input closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted while busy");

   // No result word right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (.*);
